### src/linear_blend_vertex_skinning_core_macros.svh
// Assertion macros for the checker file lbs_port_checker.sv.
`ifndef LINEAR_BLEND_VERTEX_SKINNING_CORE_MACROS_SVH
`define LINEAR_BLEND_VERTEX_SKINNING_CORE_MACROS_SVH

// Implication checked only out of reset.
`define LBS_CHECK(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbs check failed");

// Next-cycle implication, checked through reset too.
`define LBS_CHECK_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("lbs check failed");

`endif

### src/lbs_pkg.sv
package lbs_pkg;

    localparam int NUM_INF    = 4;
    localparam int POS_W      = 32;
    localparam int JIDX_W     = 8;
    localparam int WGT_W      = 17;
    localparam int CNT_W      = 7;
    localparam int LIM_W      = 9;
    localparam int WORD_IDX_W = 4;
    localparam int ROW_WORDS  = 12;
    localparam int QDEPTH     = 4;
    localparam int QAW        = 2;
    localparam int ACC_W      = 52;
    localparam int WSUM_W     = 19;

    localparam logic OP_SKIN  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic                               is_write;
        logic                               wr_ok;
        logic [WORD_IDX_W-1:0]              wr_word;
        logic [NUM_INF-1:0]                 use_inf;
        logic [2:0][POS_W-1:0]              pos;
        logic [NUM_INF-1:0][JIDX_W-1:0]     joint;
        logic [NUM_INF-1:0][WGT_W-1:0]      weight;
    } t_item;

    typedef struct packed {
        logic                   go;
        logic [WSUM_W-1:0]      den;
        logic [2:0][ACC_W-1:0]  acc;
    } t_div_req;

    typedef struct packed {
        logic                   done;
        logic [2:0][POS_W-1:0]  res;
    } t_div_rsp;

endpackage

### src/lbs_front.sv
module lbs_front #(
    parameter int MAX_JOINTS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [lbs_pkg::CNT_W-1:0]           i_cfg_wr_data,
    input  logic                                i_start,
    input  logic                                i_full,
    input  logic                                i_operation,
    input  logic [lbs_pkg::POS_W-1:0]           i_pos_x,
    input  logic [lbs_pkg::POS_W-1:0]           i_pos_y,
    input  logic [lbs_pkg::POS_W-1:0]           i_pos_z,
    input  logic [lbs_pkg::JIDX_W-1:0]          i_joint_a,
    input  logic [lbs_pkg::JIDX_W-1:0]          i_joint_b,
    input  logic [lbs_pkg::JIDX_W-1:0]          i_joint_c,
    input  logic [lbs_pkg::JIDX_W-1:0]          i_joint_d,
    input  logic [lbs_pkg::WGT_W-1:0]           i_weight_a,
    input  logic [lbs_pkg::WGT_W-1:0]           i_weight_b,
    input  logic [lbs_pkg::WGT_W-1:0]           i_weight_c,
    input  logic [lbs_pkg::WGT_W-1:0]           i_weight_d,
    output logic                                o_push,
    output lbs_pkg::t_item                      o_item
);

    localparam logic [lbs_pkg::LIM_W-1:0] MAX_LIM = lbs_pkg::LIM_W'(MAX_JOINTS);

    logic [lbs_pkg::CNT_W-1:0] r_joint_count;
    logic [lbs_pkg::LIM_W-1:0] limit;
    logic [lbs_pkg::LIM_W-1:0] cnt_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_joint_count <= '0;
        end else if (i_cfg_wr_en) begin
            r_joint_count <= i_cfg_wr_data;
        end
    end

    assign o_push  = i_start && !i_full;
    assign cnt_ext = {2'b00, r_joint_count};
    assign limit   = (cnt_ext < MAX_LIM) ? cnt_ext : MAX_LIM;

    always_comb begin
        o_item          = '0;
        o_item.is_write = (i_operation == lbs_pkg::OP_WRITE);
        o_item.pos[0]   = i_pos_x;
        o_item.pos[1]   = i_pos_y;
        o_item.pos[2]   = i_pos_z;
        o_item.joint[0] = i_joint_a;
        o_item.joint[1] = i_joint_b;
        o_item.joint[2] = i_joint_c;
        o_item.joint[3] = i_joint_d;
        o_item.weight[0] = i_weight_a;
        o_item.weight[1] = i_weight_b;
        o_item.weight[2] = i_weight_c;
        o_item.weight[3] = i_weight_d;
        for (int k = 0; k < lbs_pkg::NUM_INF; k++) begin
            o_item.use_inf[k] = (o_item.weight[k] != '0) &&
                                ({1'b0, o_item.joint[k]} < limit);
        end
        // column 3 of each row never reaches a result, so it is not stored
        o_item.wr_ok   = ({1'b0, i_joint_a} < MAX_LIM) && (i_joint_b[7:4] == 4'd0) &&
                         (i_joint_b[1:0] != 2'd3);
        o_item.wr_word = ({2'b00, i_joint_b[3:2]} << 1) + {2'b00, i_joint_b[3:2]} +
                         {2'b00, i_joint_b[1:0]};
    end

endmodule

### src/lbs_queue.sv
module lbs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lbs_pkg::t_item  i_item,
    input  logic            i_pop,
    output logic            o_valid,
    output lbs_pkg::t_item  o_item,
    output logic            o_full
);

    lbs_pkg::t_item               r_mem [lbs_pkg::QDEPTH];
    logic [lbs_pkg::QAW-1:0]      r_wp;
    logic [lbs_pkg::QAW-1:0]      r_rp;
    logic [lbs_pkg::QAW:0]        r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + {{lbs_pkg::QAW{1'b0}}, i_push} - {{lbs_pkg::QAW{1'b0}}, i_pop};
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (lbs_pkg::QAW+1)'(lbs_pkg::QDEPTH));
    assign o_item  = r_mem[r_rp];

endmodule

### src/lbs_div.sv
module lbs_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lbs_pkg::t_div_req   i_req,
    output lbs_pkg::t_div_rsp   o_rsp
);

    localparam int ACC_W  = lbs_pkg::ACC_W;
    localparam int WSUM_W = lbs_pkg::WSUM_W;
    localparam int REM_W  = WSUM_W + 1;

    logic                  r_run;
    logic                  r_done;
    logic [5:0]            r_cnt;
    logic [WSUM_W-1:0]     r_den;
    logic [REM_W-1:0]      r_rem [3];
    logic [31:0]           r_low [3];
    logic [31:0]           r_q   [3];
    logic [2:0]            r_ovf;
    logic [2:0]            r_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_run <= 1'b1;
                r_cnt <= 6'd32;
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 6'd1) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // three restoring dividers sharing one step counter
    always_ff @(posedge i_clk) begin
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] num;
        logic [REM_W-1:0] rem2;
        if (i_req.go) begin
            r_den <= i_req.den;
            for (int c = 0; c < 3; c++) begin
                mag = i_req.acc[c][ACC_W-1] ? (~i_req.acc[c] + 1'b1) : i_req.acc[c];
                num = mag + {{(ACC_W-WSUM_W){1'b0}}, i_req.den >> 1};
                r_neg[c] <= i_req.acc[c][ACC_W-1];
                r_rem[c] <= num[ACC_W-1:32];
                r_low[c] <= num[31:0];
                // quotient needs more than 32 bits
                r_ovf[c] <= (num[ACC_W-1:32] >= {1'b0, i_req.den});
                r_q[c]   <= '0;
            end
        end else if (r_run) begin
            for (int c = 0; c < 3; c++) begin
                rem2 = {r_rem[c][REM_W-2:0], r_low[c][31]};
                r_low[c] <= {r_low[c][30:0], 1'b0};
                if (rem2 >= {1'b0, r_den}) begin
                    r_rem[c] <= rem2 - {1'b0, r_den};
                    r_q[c]   <= {r_q[c][30:0], 1'b1};
                end else begin
                    r_rem[c] <= rem2;
                    r_q[c]   <= {r_q[c][30:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        for (int c = 0; c < 3; c++) begin
            if (r_neg[c]) begin
                o_rsp.res[c] = (r_ovf[c] || (r_q[c] > 32'h8000_0000)) ? 32'h8000_0000
                                                                       : (~r_q[c] + 1'b1);
            end else begin
                o_rsp.res[c] = (r_ovf[c] || r_q[c][31]) ? 32'h7FFF_FFFF : r_q[c];
            end
        end
    end

endmodule

### src/lbs_back.sv
module lbs_back #(
    parameter int MAX_JOINTS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  lbs_pkg::t_item              i_q_item,
    output logic                        o_q_pop,
    output logic                        o_valid,
    output logic [lbs_pkg::POS_W-1:0]   o_x,
    output logic [lbs_pkg::POS_W-1:0]   o_y,
    output logic [lbs_pkg::POS_W-1:0]   o_z,
    output logic                        o_passed
);

    localparam int JW     = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int ACC_W  = lbs_pkg::ACC_W;
    localparam int WSUM_W = lbs_pkg::WSUM_W;
    localparam int WGT_W  = lbs_pkg::WGT_W;

    typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_DIV} t_state;

    t_state                 r_state;
    logic [3:0]             r_k;
    lbs_pkg::t_item         r_cur;
    logic                   r_out_valid;
    logic [2:0][31:0]       r_out;
    logic                   r_out_passed;

    logic [lbs_pkg::ROW_WORDS-1:0][31:0] r_mem [MAX_JOINTS];
    logic [lbs_pkg::ROW_WORDS-1:0][31:0] r_rd;
    logic                   mem_we;
    logic [JW-1:0]          rd_addr;

    logic                   r_v0, r_v1, r_v2, r_v3;
    logic [WGT_W-1:0]       r_w0, r_w1, r_w2, r_w3;
    logic signed [63:0]     r_p  [3][3];
    logic [31:0]            r_tr [3];
    logic signed [31:0]     r_t  [3];
    logic signed [49:0]     r_tw [3];
    logic signed [ACC_W-1:0] r_acc [3];
    logic [WSUM_W-1:0]      r_wsum;

    lbs_pkg::t_div_req      div_req;
    lbs_pkg::t_div_rsp      div_rsp;

    function automatic logic signed [47:0] round_q16(input logic signed [63:0] p);
        logic signed [63:0] v;
        v = p + 64'sd32768;
        return v[63:16];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -50'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    assign o_q_pop = (r_state == ST_IDLE) && i_q_valid;
    assign mem_we  = o_q_pop && i_q_item.is_write && i_q_item.wr_ok;
    assign rd_addr = r_cur.joint[r_k[1:0]][JW-1:0];

    // palette: one row per joint, undefined until written
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_q_item.joint[0][JW-1:0]][i_q_item.wr_word] <= i_q_item.pos[0];
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v0 <= (r_state == ST_MAC) && (r_k < 4'd4) && r_cur.use_inf[r_k[1:0]];
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [49:0] sum;
        r_w0 <= r_cur.weight[r_k[1:0]];
        r_w1 <= r_w0;
        r_w2 <= r_w1;
        r_w3 <= r_w2;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                r_p[r][c] <= $signed(r_cur.pos[r]) * $signed(r_rd[r*3+c]);
            end
        end
        for (int c = 0; c < 3; c++) begin
            r_tr[c] <= r_rd[9+c];
            sum = 50'(round_q16(r_p[0][c])) + 50'(round_q16(r_p[1][c])) +
                  50'(round_q16(r_p[2][c])) + 50'($signed(r_tr[c]));
            r_t[c]  <= sat32(sum);
            r_tw[c] <= r_t[c] * $signed({1'b0, r_w2});
        end
        if (o_q_pop) begin
            r_wsum <= '0;
            for (int c = 0; c < 3; c++) begin
                r_acc[c] <= '0;
            end
        end else if (r_v3) begin
            r_wsum <= r_wsum + {{(WSUM_W-WGT_W){1'b0}}, r_w3};
            for (int c = 0; c < 3; c++) begin
                r_acc[c] <= r_acc[c] + ACC_W'(r_tw[c]);
            end
        end
    end

    always_comb begin
        div_req.go  = (r_state == ST_MAC) && (r_k == 4'd8);
        div_req.den = r_wsum;
        for (int c = 0; c < 3; c++) begin
            div_req.acc[c] = r_acc[c];
        end
    end

    lbs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_cur <= i_q_item;
                        if (!i_q_item.is_write) begin
                            if (i_q_item.use_inf == '0) begin
                                r_out_valid  <= 1'b1;
                                r_out        <= i_q_item.pos;
                                r_out_passed <= 1'b1;
                            end else begin
                                r_state <= ST_MAC;
                                r_k     <= '0;
                            end
                        end
                    end
                end
                ST_MAC: begin
                    // four reads, then the pipeline drains into the accumulator
                    r_k <= r_k + 1'b1;
                    if (r_k == 4'd8) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        r_out_valid  <= 1'b1;
                        r_out        <= div_rsp.res;
                        r_out_passed <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = r_out_valid;
    assign o_x      = r_out[0];
    assign o_y      = r_out[1];
    assign o_z      = r_out[2];
    assign o_passed = r_out_passed;

endmodule

### src/linear_blend_vertex_skinning_core.sv
// Four-influence linear blend skinning engine with a 64-joint palette.
// Command channel: an item transfers at a rising edge with i_start high and
// o_busy low. i_operation selects a vertex skin or a palette word write
// (i_pos_x = word value, i_joint_a = joint slot, i_joint_b = word 0..15;
// words 3, 7, 11 and 15 are dropped). Writes never produce a result; a skin produces exactly one.
// Results appear for one cycle with o_valid high and cannot be held off.
// Items wait in a four-entry queue, so o_busy rises only when it is full.
// A palette write or a pass-through vertex (no counted influence) is popped
// from the queue as soon as the back end is idle; the back end registers a
// pass-through result directly. A blended vertex reads its joint rows
// through the multiply-accumulate pipe, then takes 32 steps of the
// bit-serial divider by the total weight. The back end handles one blended
// vertex at a time and takes no new item until its result is out; writes
// and pass-through items retire one per cycle while the back end is idle.
// i_cfg_wr_en loads joint_count; write it only while the block is idle.
// Reset clears joint_count, the queue and all control; palette contents
// are kept and are undefined until written.
module linear_blend_vertex_skinning_core #(
    parameter int MAX_JOINTS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [lbs_pkg::CNT_W-1:0]   i_cfg_wr_data,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic                        i_operation,
    input  logic [lbs_pkg::POS_W-1:0]   i_pos_x,
    input  logic [lbs_pkg::POS_W-1:0]   i_pos_y,
    input  logic [lbs_pkg::POS_W-1:0]   i_pos_z,
    input  logic [lbs_pkg::JIDX_W-1:0]  i_joint_a,
    input  logic [lbs_pkg::JIDX_W-1:0]  i_joint_b,
    input  logic [lbs_pkg::JIDX_W-1:0]  i_joint_c,
    input  logic [lbs_pkg::JIDX_W-1:0]  i_joint_d,
    input  logic [lbs_pkg::WGT_W-1:0]   i_weight_a,
    input  logic [lbs_pkg::WGT_W-1:0]   i_weight_b,
    input  logic [lbs_pkg::WGT_W-1:0]   i_weight_c,
    input  logic [lbs_pkg::WGT_W-1:0]   i_weight_d,
    output logic                        o_valid,
    output logic [lbs_pkg::POS_W-1:0]   o_out_x,
    output logic [lbs_pkg::POS_W-1:0]   o_out_y,
    output logic [lbs_pkg::POS_W-1:0]   o_out_z,
    output logic                        o_passed_through
);

    logic           push;
    logic           pop;
    logic           q_valid;
    logic           q_full;
    lbs_pkg::t_item fe_item;
    lbs_pkg::t_item q_item;

    lbs_front #(.MAX_JOINTS(MAX_JOINTS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_start       (i_start),
        .i_full        (q_full),
        .i_operation   (i_operation),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_joint_a     (i_joint_a),
        .i_joint_b     (i_joint_b),
        .i_joint_c     (i_joint_c),
        .i_joint_d     (i_joint_d),
        .i_weight_a    (i_weight_a),
        .i_weight_b    (i_weight_b),
        .i_weight_c    (i_weight_c),
        .i_weight_d    (i_weight_d),
        .o_push        (push),
        .o_item        (fe_item)
    );

    lbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (fe_item),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item),
        .o_full  (q_full)
    );

    lbs_back #(.MAX_JOINTS(MAX_JOINTS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (pop),
        .o_valid   (o_valid),
        .o_x       (o_out_x),
        .o_y       (o_out_y),
        .o_z       (o_out_z),
        .o_passed  (o_passed_through)
    );

    assign o_busy = q_full;

endmodule

### src/lbs_port_checker.sv
`include "linear_blend_vertex_skinning_core_macros.svh"

module lbs_port_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic o_busy,
    input  logic i_operation,
    input  logic o_valid
);

    logic [3:0] r_pending;
    logic       skin_in;

    assign skin_in = i_start && !o_busy && (i_operation == lbs_pkg::OP_SKIN);

    // skins transferred but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {3'b000, skin_in} - {3'b000, o_valid};
        end
    end

    `LBS_CHECK_NEXT(a_reset_quiet, i_clk, !i_rst_n, !o_valid && !o_busy)
    `LBS_CHECK(a_no_orphan_result, i_clk, i_rst_n, o_valid, r_pending != 4'd0)
    `LBS_CHECK(a_pending_bound, i_clk, i_rst_n, 1'b1, r_pending <= 4'(lbs_pkg::QDEPTH + 1))

endmodule

bind linear_blend_vertex_skinning_core lbs_port_checker u_port_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_operation (i_operation),
    .o_valid     (o_valid)
);
